>>> design/idas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idas_pkg: shared definitions for the integer to decimal ASCII formatter
// Holds the field widths, the character codes and the data types that travel
// between the conversion pipeline and the character serializer.
// ----------------------------------------------------------------------------
package idas_pkg;

   localparam int VALUE_WIDTH     = 64;
   localparam int NUM_DIGITS      = 19;
   localparam int DIGIT_WIDTH     = 4;
   localparam int BCD_WIDTH       = NUM_DIGITS * DIGIT_WIDTH;
   localparam int DIGIT_IDX_WIDTH = $clog2(NUM_DIGITS);
   localparam int BITS_PER_STAGE  = 8;
   localparam int CHAR_WIDTH      = 8;

   localparam logic [CHAR_WIDTH-1:0]  CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_WIDTH-1:0]  CHAR_MINUS = 8'd45;
   localparam logic [DIGIT_WIDTH-1:0] DABBLE_LIMIT = 4'd5;
   localparam logic [DIGIT_WIDTH-1:0] DABBLE_ADD   = 4'd3;

   typedef struct packed {
      logic                   negative;
      logic [VALUE_WIDTH-1:0] bin;
      logic [BCD_WIDTH-1:0]   bcd;
   } conv_type;

   typedef struct packed {
      logic                 negative;
      logic [BCD_WIDTH-1:0] bcd;
   } word_type;

endpackage

>>> design/idas_dabble_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idas_dabble_stage: one register stage of the binary to BCD converter
// Shifts a fixed number of magnitude bits into the BCD digits with the
// add-three correction, then registers the result with its valid bit.
// ----------------------------------------------------------------------------
module idas_dabble_stage #(
   parameter int BITS_PER_STAGE = idas_pkg::BITS_PER_STAGE
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_stall,
   input  idas_pkg::conv_type in_data,
   output logic               out_valid,
   input  logic               out_stall,
   output idas_pkg::conv_type out_data
);

   logic               valid_ff;
   idas_pkg::conv_type data_ff;
   idas_pkg::conv_type data_in;
   logic               advance;

   assign advance  = !(valid_ff && out_stall);
   assign in_stall = !advance;

   always_comb begin
      logic [idas_pkg::VALUE_WIDTH-1:0] bin;
      logic [idas_pkg::BCD_WIDTH-1:0]   bcd;
      bin = in_data.bin;
      bcd = in_data.bcd;
      for (int s = 0; s < BITS_PER_STAGE; s++) begin
         for (int d = 0; d < idas_pkg::NUM_DIGITS; d++) begin
            if (bcd[d*idas_pkg::DIGIT_WIDTH +: idas_pkg::DIGIT_WIDTH] >=
                idas_pkg::DABBLE_LIMIT) begin
               bcd[d*idas_pkg::DIGIT_WIDTH +: idas_pkg::DIGIT_WIDTH] =
                  bcd[d*idas_pkg::DIGIT_WIDTH +: idas_pkg::DIGIT_WIDTH] +
                  idas_pkg::DABBLE_ADD;
            end
         end
         bcd = {bcd[idas_pkg::BCD_WIDTH-2:0], bin[idas_pkg::VALUE_WIDTH-1]};
         bin = {bin[idas_pkg::VALUE_WIDTH-2:0], 1'b0};
      end
      data_in.negative = in_data.negative;
      data_in.bin      = bin;
      data_in.bcd      = bcd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> design/idas_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idas_serializer: character serializer of the decimal formatter
// Takes one converted number, finds its leading digit and sends the sign and
// the digits through a registered output, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module idas_serializer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_stall,
   input  idas_pkg::word_type                  in_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [idas_pkg::CHAR_WIDTH-1:0]     rsp_char_code,
   output logic                                rsp_last_char
);

   localparam int IW = idas_pkg::DIGIT_IDX_WIDTH;

   logic                                active_ff, active_in;
   logic                                sign_ff, sign_in;
   logic [IW-1:0]                       pos_ff, pos_in;
   logic [idas_pkg::DIGIT_WIDTH-1:0]    dig_ff [idas_pkg::NUM_DIGITS];
   logic                                rsp_valid_ff;
   logic [idas_pkg::CHAR_WIDTH-1:0]     rsp_char_ff;
   logic                                rsp_last_ff;
   logic                                out_free;
   logic                                emit;
   logic                                last_now;
   logic                                done;
   logic                                accept;
   logic [IW-1:0]                       msd;
   logic [idas_pkg::CHAR_WIDTH-1:0]     char_now;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = active_ff && out_free;
   assign last_now = !sign_ff && (pos_ff == '0);
   assign done     = emit && last_now;
   assign in_stall = active_ff && !done;
   assign accept   = in_valid && !in_stall;

   always_comb begin
      msd = '0;
      for (int i = 0; i < idas_pkg::NUM_DIGITS; i++) begin
         if (in_word.bcd[i*idas_pkg::DIGIT_WIDTH +: idas_pkg::DIGIT_WIDTH] != '0) begin
            msd = IW'(i);
         end
      end
   end

   always_comb begin
      active_in = active_ff;
      sign_in   = sign_ff;
      pos_in    = pos_ff;
      if (done) begin
         active_in = 1'b0;
      end
      if (accept) begin
         active_in = 1'b1;
         sign_in   = in_word.negative;
         pos_in    = msd;
      end else if (emit) begin
         if (sign_ff) begin
            sign_in = 1'b0;
         end else begin
            pos_in = pos_ff - IW'(1);
         end
      end
   end

   always_comb begin
      if (sign_ff) begin
         char_now = idas_pkg::CHAR_MINUS;
      end else begin
         char_now = idas_pkg::CHAR_ZERO +
                    {{(idas_pkg::CHAR_WIDTH-idas_pkg::DIGIT_WIDTH){1'b0}}, dig_ff[pos_ff]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         sign_ff      <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         sign_ff   <= sign_in;
         pos_ff    <= pos_in;
         if (out_free) begin
            rsp_valid_ff <= active_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < idas_pkg::NUM_DIGITS; i++) begin
            dig_ff[i] <= in_word.bcd[i*idas_pkg::DIGIT_WIDTH +: idas_pkg::DIGIT_WIDTH];
         end
      end
      if (emit) begin
         rsp_char_ff <= char_now;
         rsp_last_ff <= last_now;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_char_ff == idas_pkg::CHAR_MINUS) |-> !rsp_last_ff)
      else $error("A minus sign was flagged as the last character.");

   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (active_ff && !out_free) |=> ($stable(pos_ff) && $stable(sign_ff)))
      else $error("The serializer advanced while its output was blocked.");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (emit && !last_now) |=> active_ff)
      else $error("The serializer dropped a request before its last character.");

endmodule

>>> design/int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_to_decimal_ascii: signed 64-bit integer to decimal ASCII text
// Each request carries one signed integer; the block answers with its decimal
// text, a leading minus sign for negative values, most significant digit
// first, and the last character of the text flagged.
// ----------------------------------------------------------------------------
// A request first passes a magnitude stage and then 64 / BITS_PER_STAGE
// binary to BCD stages (eight with the default), then the serializer, whose
// output is registered. The serializer sends one character per cycle while
// rsp_stall is low; one request gives 1 to 20 characters: the number of
// digits plus one for a minus sign. The pipeline takes a request in every
// cycle until it fills behind the serializer, so the sustained rate is one
// character per cycle when the output does not stall.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii #(
   parameter int BITS_PER_STAGE = idas_pkg::BITS_PER_STAGE
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [idas_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [idas_pkg::CHAR_WIDTH-1:0]        rsp_char_code,
   output logic                                   rsp_last_char
);

   localparam int NUM_STAGES = idas_pkg::VALUE_WIDTH / BITS_PER_STAGE;

   logic               mag_valid_ff;
   idas_pkg::conv_type mag_data_ff;
   idas_pkg::conv_type mag_data_in;
   logic               mag_advance;

   logic               stage_valid [NUM_STAGES+1];
   logic               stage_stall [NUM_STAGES+1];
   idas_pkg::conv_type stage_data  [NUM_STAGES+1];
   idas_pkg::word_type ser_word;

   assign mag_advance = !(mag_valid_ff && stage_stall[0]);
   assign req_stall   = !mag_advance;

   always_comb begin
      mag_data_in.negative = req_value[idas_pkg::VALUE_WIDTH-1];
      if (req_value[idas_pkg::VALUE_WIDTH-1]) begin
         mag_data_in.bin = '0 - req_value;
      end else begin
         mag_data_in.bin = req_value;
      end
      mag_data_in.bcd = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_valid_ff <= 1'b0;
      end else if (mag_advance) begin
         mag_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (mag_advance) begin
         mag_data_ff <= mag_data_in;
      end
   end

   assign stage_valid[0] = mag_valid_ff;
   assign stage_data[0]  = mag_data_ff;

   for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
      idas_dabble_stage #(
         .BITS_PER_STAGE (BITS_PER_STAGE)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[g]),
         .in_stall  (stage_stall[g]),
         .in_data   (stage_data[g]),
         .out_valid (stage_valid[g+1]),
         .out_stall (stage_stall[g+1]),
         .out_data  (stage_data[g+1])
      );
   end

   assign ser_word.negative = stage_data[NUM_STAGES].negative;
   assign ser_word.bcd      = stage_data[NUM_STAGES].bcd;

   idas_serializer u_serializer (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (stage_valid[NUM_STAGES]),
      .in_stall      (stage_stall[NUM_STAGES]),
      .in_word       (ser_word),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char)
   );

endmodule

>>> tb/idas_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idas_checker: scoreboard for the integer to decimal ASCII formatter
// Watches the request and character channels, works out the decimal text of
// every accepted request, and compares each accepted character and its
// last-character flag with the oldest character still expected.
// ----------------------------------------------------------------------------
module idas_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_stall,
   input  logic signed [idas_pkg::VALUE_WIDTH-1:0] req_value,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   input  logic [idas_pkg::CHAR_WIDTH-1:0]         rsp_char_code,
   input  logic                                    rsp_last_char,
   output int                                      fail_count,
   output int                                      pending
);

   localparam logic [idas_pkg::VALUE_WIDTH-1:0] RADIX       = 64'd10;
   localparam int                               MAX_DIGITS  = 20;
   localparam int                               PRINT_LIMIT = 100;

   typedef struct packed {
      logic [idas_pkg::CHAR_WIDTH-1:0] code;
      logic                            is_last;
   } text_char_type;

   text_char_type expected_text [$];
   text_char_type oldest_char;
   int            mismatch_count = 0;
   int            chars_waiting  = 0;

   assign fail_count = mismatch_count;
   assign pending    = chars_waiting;

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("%0t ns: mismatch, %s", $time, what);
      end
      mismatch_count++;
   endtask

   function automatic void predict_text(input logic [idas_pkg::VALUE_WIDTH-1:0] value);
      logic [idas_pkg::VALUE_WIDTH-1:0] magnitude;
      logic [idas_pkg::CHAR_WIDTH-1:0]  digits [0:MAX_DIGITS-1];
      text_char_type                    entry;
      int                               count;
      magnitude = value[idas_pkg::VALUE_WIDTH-1] ? (~value + 64'd1) : value;
      count = 0;
      digits[0] = idas_pkg::CHAR_ZERO;
      do begin
         digits[count] = idas_pkg::CHAR_ZERO + 8'(magnitude % RADIX);
         magnitude = magnitude / RADIX;
         count++;
      end while (magnitude != 0);
      if (value[idas_pkg::VALUE_WIDTH-1]) begin
         entry.code    = idas_pkg::CHAR_MINUS;
         entry.is_last = 1'b0;
         expected_text.push_back(entry);
      end
      for (int k = count - 1; k >= 0; k--) begin
         entry.code    = digits[k];
         entry.is_last = (k == 0);
         expected_text.push_back(entry);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_text(req_value);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_text.size() == 0) begin
               report_mismatch($sformatf("character %0d arrived with nothing expected",
                                         rsp_char_code));
            end else begin
               oldest_char = expected_text.pop_front();
               if (rsp_char_code !== oldest_char.code) begin
                  report_mismatch($sformatf("char_code %0d, expected %0d",
                                            rsp_char_code, oldest_char.code));
               end
               if (rsp_last_char !== oldest_char.is_last) begin
                  report_mismatch($sformatf("last_char %0b, expected %0b on char %0d",
                                            rsp_last_char, oldest_char.is_last,
                                            oldest_char.code));
               end
            end
         end
      end
      chars_waiting = expected_text.size();
   end

endmodule

>>> tb/tb_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_int_to_decimal_ascii: testbench for the integer to decimal ASCII formatter
// Sends directed corner values and then random values of every length and
// sign in bursts with random gaps, while the character side stalls in changing
// patterns and once holds off long enough to back the block up. A separate
// checker predicts and compares every character; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_int_to_decimal_ascii;

   localparam int RANDOM_REQUESTS = 200;
   localparam int HOLD_CYCLES     = 400;
   localparam int QUIET_LIMIT     = 3000;
   localparam int TAIL_CYCLES     = 30;

   typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_PULSE} flow_mode_type;

   logic                                    clock;
   logic                                    reset;
   logic                                    req_valid;
   logic                                    req_stall;
   logic signed [idas_pkg::VALUE_WIDTH-1:0] req_value;
   logic                                    rsp_valid;
   logic                                    rsp_stall;
   logic [idas_pkg::CHAR_WIDTH-1:0]         rsp_char_code;
   logic                                    rsp_last_char;
   int                                      fail_count;
   int                                      pending;
   int                                      quiet_cycles = 0;
   logic                                    hold_request = 1'b0;

   int_to_decimal_ascii i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char)
   );

   idas_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char),
      .fail_count    (fail_count),
      .pending       (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout after %0d cycles without a transfer", quiet_cycles);
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // The character side cycles through stall patterns and honors one long
   // hold-off when the request side asks for it.
   initial begin
      flow_mode_type mode;
      int            span;
      int            phase;
      rsp_stall = 1'b0;
      mode  = FLOW_FREE;
      span  = 0;
      phase = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            if (span == 0) begin
               mode = flow_mode_type'($urandom_range(0, 3));
               span = $urandom_range(20, 150);
            end
            span--;
            phase++;
            case (mode)
               FLOW_FREE:  rsp_stall <= 1'b0;
               FLOW_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               FLOW_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:    rsp_stall <= (phase % 5 < 2);
            endcase
         end
      end
   end

   task automatic send_value(input logic [idas_pkg::VALUE_WIDTH-1:0] value);
      @(negedge clock);
      req_valid <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic drain_text();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   function automatic logic [idas_pkg::VALUE_WIDTH-1:0] random_value();
      logic [idas_pkg::VALUE_WIDTH-1:0] value;
      logic [idas_pkg::VALUE_WIDTH-1:0] power;
      int                               pick;
      int                               bits;
      pick  = $urandom_range(0, 9);
      value = {$urandom(), $urandom()};
      if (pick <= 5) begin
         bits = $urandom_range(1, idas_pkg::VALUE_WIDTH);
         if (bits < idas_pkg::VALUE_WIDTH) begin
            value = value & ((64'd1 << bits) - 64'd1);
            if ($urandom_range(0, 1) == 1) value = ~value + 64'd1;
         end
      end else if (pick <= 7) begin
         power = 64'd1;
         repeat ($urandom_range(0, 18)) power = power * 64'd10;
         value = power + $urandom_range(0, 2) - 64'd1;
         if ($urandom_range(0, 1) == 1) value = ~value + 64'd1;
      end else if (pick == 9) begin
         case ($urandom_range(0, 3))
            0:       value = 64'h8000_0000_0000_0000;
            1:       value = 64'h7FFF_FFFF_FFFF_FFFF;
            2:       value = 64'd0;
            default: value = 64'hFFFF_FFFF_FFFF_FFFF;
         endcase
      end
      return value;
   endfunction

   initial begin
      logic [idas_pkg::VALUE_WIDTH-1:0] corner_values [$];
      int                               sent;
      int                               burst;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      corner_values = '{64'd0, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd9, 64'd10,
                        ~64'd10 + 64'd1, ~64'd9 + 64'd1, 64'd99, 64'd100,
                        64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                        64'h8000_0000_0000_0001, 64'd999999999999999999,
                        64'd1000000000000000000, ~64'd1000000000000000000 + 64'd1,
                        64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                        64'd1234567890123456789, 64'd4294967296};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (corner_values[i]) send_value(corner_values[i]);
      drain_text();

      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         burst = $urandom_range(1, 16);
         for (int b = 0; b < burst && sent < RANDOM_REQUESTS; b++) begin
            send_value(random_value());
            sent++;
            if (sent == 60) hold_request = 1'b1;
            if (sent == 130) drain_text();
         end
         if (sent >= 150 && sent < 180) begin
         end else if ($urandom_range(0, 3) != 0) begin
            pause_sender($urandom_range(1, 8));
         end
      end

      drain_text();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
